[rtl/core/lpmrt_pkg.sv]
// Shared types, codes and helpers for the IPv6 longest-prefix route table.
`timescale 1ns / 1ps

package lpmrt_pkg;

  // Request kinds
  typedef enum logic [1:0] {
    KIND_ADD    = 2'd0,
    KIND_REMOVE = 2'd1,
    KIND_FLUSH  = 2'd2,
    KIND_LOOKUP = 2'd3
  } kind_e;

  // Sequencer states, one-hot
  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_DONE = 3'b100
  } state_e;

  localparam logic [7:0]  PLEN_MAX     = 8'd128;
  localparam logic [15:0] MCAST_PREFIX = 16'hFF02;

  // One stored route
  typedef struct packed {
    logic [63:0] dest_high;
    logic [63:0] dest_low;
    logic [7:0]  prefix_len;
    logic [63:0] hop_high;
    logic [63:0] hop_low;
    logic [3:0]  iface;
  } entry_t;

  // Latched request, prefix length already clamped
  typedef struct packed {
    kind_e       kind;
    logic [63:0] addr_high;
    logic [63:0] addr_low;
    logic [7:0]  prefix_len;
    logic [3:0]  iface;
    logic        iface_given;
  } req_t;

  // Per-entry compare flags
  typedef struct packed {
    logic rm_hit;
    logic fl_hit;
    logic lk_hit;
  } cmp_t;

  // Result transaction
  typedef struct packed {
    logic        route_found;
    logic [63:0] out_hop_high;
    logic [63:0] out_hop_low;
    logic [3:0]  out_iface;
    logic [63:0] out_dest_high;
    logic [63:0] out_dest_low;
    logic [7:0]  out_prefix_len;
    logic        table_full;
    logic [5:0]  removed_count;
  } res_t;

  // Leading-ones mask for a prefix length of 0..128
  function automatic logic [127:0] prefix_mask(input logic [7:0] len);
    logic [7:0] sh;
    sh = PLEN_MAX - len;
    return {128{1'b1}} << sh;
  endfunction

endpackage

[rtl/core/lpmrt_req_if.sv]
// Request channel: valid/ready handshake with the route table request fields.
`timescale 1ns / 1ps

interface lpmrt_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [63:0] addr_high;
  logic [63:0] addr_low;
  logic [7:0]  prefix_len;
  logic [63:0] hop_high;
  logic [63:0] hop_low;
  logic [3:0]  iface;
  logic        iface_given;

  modport source (
    output valid, kind, addr_high, addr_low, prefix_len, hop_high, hop_low, iface,
           iface_given,
    input  ready
  );

  modport sink (
    input  valid, kind, addr_high, addr_low, prefix_len, hop_high, hop_low, iface,
           iface_given,
    output ready
  );
endinterface

[rtl/core/lpmrt_rsp_if.sv]
// Response channel: valid/ready handshake with the route table result fields.
`timescale 1ns / 1ps

interface lpmrt_rsp_if;
  logic        valid;
  logic        ready;
  logic        route_found;
  logic [63:0] out_hop_high;
  logic [63:0] out_hop_low;
  logic [3:0]  out_iface;
  logic [63:0] out_dest_high;
  logic [63:0] out_dest_low;
  logic [7:0]  out_prefix_len;
  logic        table_full;
  logic [5:0]  removed_count;

  modport source (
    output valid, route_found, out_hop_high, out_hop_low, out_iface, out_dest_high,
           out_dest_low, out_prefix_len, table_full, removed_count,
    input  ready
  );

  modport sink (
    input  valid, route_found, out_hop_high, out_hop_low, out_iface, out_dest_high,
           out_dest_low, out_prefix_len, table_full, removed_count,
    output ready
  );
endinterface

[rtl/core/lpmrt_cmp.sv]
// Shared entry compare unit: remove, flush and prefix-match tests for one route.
`timescale 1ns / 1ps

module lpmrt_cmp (
  input  lpmrt_pkg::entry_t entry_i,
  input  lpmrt_pkg::req_t   key_i,
  output lpmrt_pkg::cmp_t   cmp_o
);

  logic [127:0] mask;
  logic [127:0] diff;
  logic         iface_eq;

  assign mask     = lpmrt_pkg::prefix_mask(entry_i.prefix_len);
  assign diff     = {key_i.addr_high ^ entry_i.dest_high, key_i.addr_low ^ entry_i.dest_low};
  assign iface_eq = (entry_i.iface == key_i.iface);

  // Remove: exact destination and prefix length
  assign cmp_o.rm_hit = (entry_i.dest_high == key_i.addr_high) &&
                        (entry_i.dest_low == key_i.addr_low) &&
                        (entry_i.prefix_len == key_i.prefix_len);
  // Flush: same interface
  assign cmp_o.fl_hit = iface_eq;
  // Lookup: masked address match, optionally restricted to one interface
  assign cmp_o.lk_hit = ((diff & mask) == 128'd0) && (!key_i.iface_given || iface_eq);

endmodule

[rtl/core/ipv6_longest_prefix_route_table_unit.sv]
// Top level of the IPv6 longest-prefix route table.
`timescale 1ns / 1ps

// Route table of MAX_ROUTES entries kept in insertion order in one on-chip
// memory with a registered read port. One request is handled at a time;
// req_i.ready is high only while the unit is idle. An add, a link-local
// multicast lookup, or any request against an empty table goes from accept
// straight to the result, with no table walk. Remove, flush and other
// lookups walk the table one entry per cycle through a single compare unit:
// the first entry is read as the request is accepted, each stored route is
// compared in turn, then the result is presented. Remove and flush compact
// the table in place during the same walk. The unit returns to idle once
// the result transaction is taken. No clearing pass after reset.

module ipv6_longest_prefix_route_table_unit #(
  parameter int MAX_ROUTES = 32,
  parameter int NUM_IFACES = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  lpmrt_req_if.sink         req_i,
  lpmrt_rsp_if.source       rsp_o
);

  localparam int IW = (MAX_ROUTES > 1) ? $clog2(MAX_ROUTES) : 1;
  localparam int CW = $clog2(MAX_ROUTES + 1);
  localparam logic [CW-1:0] CountMax = CW'(MAX_ROUTES);
  localparam logic [8:0]    IfaceLim = 9'(NUM_IFACES);

  lpmrt_pkg::state_e state_q, state_d;
  lpmrt_pkg::req_t   req_q, req_d;
  lpmrt_pkg::res_t   res_q, res_d;
  lpmrt_pkg::kind_e  kind_in;
  lpmrt_pkg::cmp_t   cmp;

  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] proc_q, proc_d;
  logic [CW-1:0] keep_q, keep_d;
  logic [CW-1:0] gone_q, gone_d;
  logic [7:0]    longest_q, longest_d;
  logic          found_q, found_d;
  logic [CW-1:0] proc_next;
  logic          last_entry;
  logic          del_hit;

  // Route memory
  lpmrt_pkg::entry_t mem_q [MAX_ROUTES];
  lpmrt_pkg::entry_t rd_data_q;
  lpmrt_pkg::entry_t wr_data;
  logic [IW-1:0]     rd_addr;
  logic [IW-1:0]     wr_addr;
  logic              wr_en;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    rd_data_q <= mem_q[rd_addr];
  end

  // Shared compare unit on the entry just read
  lpmrt_cmp u_cmp (
    .entry_i (rd_data_q),
    .key_i   (req_q),
    .cmp_o   (cmp)
  );

  assign kind_in    = lpmrt_pkg::kind_e'(req_i.kind);
  assign proc_next  = proc_q + CW'(1);
  assign last_entry = (proc_next == count_q);
  assign del_hit    = (req_q.kind == lpmrt_pkg::KIND_REMOVE) ? cmp.rm_hit : cmp.fl_hit;

  // Sequencer
  always_comb begin
    state_d   = state_q;
    req_d     = req_q;
    res_d     = res_q;
    count_d   = count_q;
    proc_d    = proc_q;
    keep_d    = keep_q;
    gone_d    = gone_q;
    longest_d = longest_q;
    found_d   = found_q;
    wr_en     = 1'b0;
    wr_addr   = keep_q[IW-1:0];
    wr_data   = rd_data_q;
    rd_addr   = '0;

    case (state_q)
      lpmrt_pkg::ST_IDLE: begin
        if (req_i.valid) begin
          req_d.kind        = kind_in;
          req_d.addr_high   = req_i.addr_high;
          req_d.addr_low    = req_i.addr_low;
          req_d.prefix_len  = (req_i.prefix_len > lpmrt_pkg::PLEN_MAX) ?
                              lpmrt_pkg::PLEN_MAX : req_i.prefix_len;
          req_d.iface       = req_i.iface;
          req_d.iface_given = req_i.iface_given;
          res_d     = '0;
          proc_d    = '0;
          keep_d    = '0;
          gone_d    = '0;
          longest_d = '0;
          found_d   = 1'b0;
          state_d   = lpmrt_pkg::ST_DONE;
          case (kind_in)
            lpmrt_pkg::KIND_ADD: begin
              if ({5'd0, req_i.iface} < IfaceLim) begin
                if (count_q >= CountMax) begin
                  res_d.table_full = 1'b1;
                end else begin
                  wr_en              = 1'b1;
                  wr_addr            = count_q[IW-1:0];
                  wr_data.dest_high  = req_i.addr_high;
                  wr_data.dest_low   = req_i.addr_low;
                  wr_data.prefix_len = req_d.prefix_len;
                  wr_data.hop_high   = req_i.hop_high;
                  wr_data.hop_low    = req_i.hop_low;
                  wr_data.iface      = req_i.iface;
                  count_d            = count_q + CW'(1);
                end
              end
            end
            lpmrt_pkg::KIND_LOOKUP: begin
              if (req_i.addr_high[63:48] == lpmrt_pkg::MCAST_PREFIX) begin
                // link-local multicast: answered without the table
                if (req_i.iface_given) begin
                  res_d.route_found   = 1'b1;
                  res_d.out_iface     = req_i.iface;
                  res_d.out_dest_high = req_i.addr_high;
                  res_d.out_dest_low  = req_i.addr_low;
                end
              end else if (count_q != '0) begin
                state_d = lpmrt_pkg::ST_SCAN;
              end
            end
            lpmrt_pkg::KIND_REMOVE, lpmrt_pkg::KIND_FLUSH: begin
              if (count_q != '0) begin
                state_d = lpmrt_pkg::ST_SCAN;
              end
            end
            default: begin
              state_d = lpmrt_pkg::ST_DONE;
            end
          endcase
        end
      end

      lpmrt_pkg::ST_SCAN: begin
        rd_addr = proc_next[IW-1:0];
        proc_d  = proc_next;
        if (req_q.kind == lpmrt_pkg::KIND_LOOKUP) begin
          // later entry wins a tie
          if (cmp.lk_hit && (rd_data_q.prefix_len >= longest_q)) begin
            longest_d            = rd_data_q.prefix_len;
            found_d              = 1'b1;
            res_d.out_hop_high   = rd_data_q.hop_high;
            res_d.out_hop_low    = rd_data_q.hop_low;
            res_d.out_iface      = rd_data_q.iface;
            res_d.out_dest_high  = rd_data_q.dest_high;
            res_d.out_dest_low   = rd_data_q.dest_low;
            res_d.out_prefix_len = rd_data_q.prefix_len;
          end
        end else if (del_hit) begin
          gone_d = gone_q + CW'(1);
        end else begin
          // survivor slides down over the gap
          wr_en   = (keep_q != proc_q);
          wr_addr = keep_q[IW-1:0];
          keep_d  = keep_q + CW'(1);
        end
        if (last_entry) begin
          state_d = lpmrt_pkg::ST_DONE;
          if (req_q.kind == lpmrt_pkg::KIND_LOOKUP) begin
            res_d.route_found = found_d;
          end else begin
            count_d             = keep_d;
            res_d.removed_count = 6'(gone_d);
          end
        end
      end

      lpmrt_pkg::ST_DONE: begin
        if (rsp_o.ready) begin
          state_d = lpmrt_pkg::ST_IDLE;
        end
      end

      default: begin
        state_d = lpmrt_pkg::ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= lpmrt_pkg::ST_IDLE;
      count_q   <= '0;
      proc_q    <= '0;
      keep_q    <= '0;
      gone_q    <= '0;
      longest_q <= '0;
      found_q   <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      proc_q    <= proc_d;
      keep_q    <= keep_d;
      gone_q    <= gone_d;
      longest_q <= longest_d;
      found_q   <= found_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    req_q <= req_d;
    res_q <= res_d;
  end

  // Ports
  assign req_i.ready          = (state_q == lpmrt_pkg::ST_IDLE);
  assign rsp_o.valid          = (state_q == lpmrt_pkg::ST_DONE);
  assign rsp_o.route_found    = res_q.route_found;
  assign rsp_o.out_hop_high   = res_q.out_hop_high;
  assign rsp_o.out_hop_low    = res_q.out_hop_low;
  assign rsp_o.out_iface      = res_q.out_iface;
  assign rsp_o.out_dest_high  = res_q.out_dest_high;
  assign rsp_o.out_dest_low   = res_q.out_dest_low;
  assign rsp_o.out_prefix_len = res_q.out_prefix_len;
  assign rsp_o.table_full     = res_q.table_full;
  assign rsp_o.removed_count  = res_q.removed_count;

`ifndef ASSERT_OFF
  // table never holds more than its capacity
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CountMax)
    else $error("entry count above capacity");

  // every entry scanned by a delete is either kept or deleted
  a_scan_balance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == lpmrt_pkg::ST_SCAN) && (req_q.kind != lpmrt_pkg::KIND_LOOKUP))
      |-> (keep_q + gone_q == proc_q))
    else $error("compaction counters out of step");

  // scan never runs past the stored entries
  a_scan_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == lpmrt_pkg::ST_SCAN) |-> (proc_q < count_q))
    else $error("scan index beyond entry count");

  // a full report only when the table really is full
  a_full_report: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && rsp_o.table_full) |-> (count_q == CountMax))
    else $error("table_full reported with free space");

  // a delete never grows the table
  a_delete_shrinks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == lpmrt_pkg::ST_SCAN) && (req_q.kind != lpmrt_pkg::KIND_LOOKUP))
      |=> (count_q <= $past(count_q)))
    else $error("delete increased entry count");
`endif

endmodule
